@@ design/cr3_pkg.sv @@
// shared widths, pipeline depths and saturation codes for the 3x3 cramer solver
// no dependencies
package cr3_pkg;

  localparam int DATA_W  = 32;
  // exact 3x3 determinant of 32-bit entries fits in 99 bits, one spare
  localparam int DW      = 100;
  localparam int DET_LAT = 5;
  localparam int DIV_LAT = 35;

  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

@@ design/cr3_det.sv @@
// five-stage pipelined exact 3x3 determinant, cofactor expansion on row 0
// depends on cr3_pkg
module cr3_det import cr3_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] m [9],
  output logic signed [DW-1:0]     det
);

  logic signed [2*DATA_W-1:0] p  [6];
  logic signed [DATA_W-1:0]   r1 [3];
  logic signed [DATA_W-1:0]   r2 [3];
  logic signed [2*DATA_W:0]   c  [3];
  logic signed [2*DATA_W:0]   lo [3];
  logic signed [2*DATA_W:0]   hi [3];
  logic signed [DW-1:0]       t  [3];

  always_ff @(posedge clk) begin
    if (en) begin
      // 2x2 minor products
      p[0] <= m[4] * m[8];
      p[1] <= m[5] * m[7];
      p[2] <= m[3] * m[8];
      p[3] <= m[5] * m[6];
      p[4] <= m[3] * m[7];
      p[5] <= m[4] * m[6];
      r1   <= m[0:2];
      for (int j = 0; j < 3; j++) begin
        c[j] <= (2*DATA_W+1)'(p[2*j]) - (2*DATA_W+1)'(p[2*j+1]);
      end
      r2 <= r1;
      // minor split into signed upper and unsigned lower halves
      for (int j = 0; j < 3; j++) begin
        lo[j] <= $signed({1'b0, c[j][DATA_W-1:0]}) * r2[j];
        hi[j] <= $signed(c[j][2*DATA_W:DATA_W]) * r2[j];
      end
      for (int j = 0; j < 3; j++) begin
        t[j] <= (DW'(hi[j]) <<< DATA_W) + DW'(lo[j]);
      end
      det <= t[0] - t[1] + t[2];
    end
  end

endmodule

@@ design/cr3_div.sv @@
// pipelined signed fixed-point divide with saturation and singular override
// one quotient bit per stage; depends on cr3_pkg
module cr3_div import cr3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DW-1:0]     num,
  input  logic signed [DW-1:0]     den,
  output logic        [DATA_W-1:0] sol,
  output logic                     singular
);

  localparam int NW = DW + FRAC_BITS;
  localparam int RW = (NW > DW + DATA_W + 1) ? NW : DW + DATA_W + 1;
  localparam logic [DATA_W-1:0] NEG_ONE = ~((DATA_W'(1) << FRAC_BITS) - DATA_W'(1));

  logic [DW-1:0] abs_num;
  logic [DW-1:0] abs_den;
  logic [RW-1:0] pn;
  logic [DW-1:0] pd;
  logic          pneg;
  logic          pz;

  logic [RW-1:0]     sr   [33];
  logic [DATA_W-1:0] sq   [33];
  logic [DW-1:0]     sd   [33];
  logic              sneg [33];
  logic              sz   [33];
  logic              sovf [33];

  logic [DATA_W-1:0] q;

  assign abs_num = num[DW-1] ? DW'(-num) : DW'(num);
  assign abs_den = den[DW-1] ? DW'(-den) : DW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      pn   <= RW'(abs_num) << FRAC_BITS;
      pd   <= abs_den;
      pneg <= num[DW-1] ^ den[DW-1];
      pz   <= (den == '0);
      // quotient of 2^32 or more saturates
      sovf[0] <= (pn >= (RW'(pd) << DATA_W));
      sr[0]   <= pn;
      sq[0]   <= '0;
      sd[0]   <= pd;
      sneg[0] <= pneg;
      sz[0]   <= pz;
    end
  end

  for (genvar i = 0; i < DATA_W; i++) begin : g_bit
    logic [RW-1:0] trial;
    assign trial = RW'(sd[i]) << (DATA_W - 1 - i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (sr[i] >= trial) begin
          sr[i+1] <= sr[i] - trial;
          sq[i+1] <= sq[i] | (DATA_W'(1) << (DATA_W - 1 - i));
        end else begin
          sr[i+1] <= sr[i];
          sq[i+1] <= sq[i];
        end
        sd[i+1]   <= sd[i];
        sneg[i+1] <= sneg[i];
        sz[i+1]   <= sz[i];
        sovf[i+1] <= sovf[i];
      end
    end
  end

  assign q = sq[DATA_W];

  always_ff @(posedge clk) begin
    if (en) begin
      singular <= sz[DATA_W];
      if (sz[DATA_W]) begin
        sol <= NEG_ONE;
      end else if (sovf[DATA_W]) begin
        sol <= sneg[DATA_W] ? SAT_NEG : SAT_POS;
      end else if (!sneg[DATA_W]) begin
        sol <= (q > SAT_POS) ? SAT_POS : q;
      end else begin
        sol <= (q > SAT_NEG) ? SAT_NEG : DATA_W'(-q);
      end
    end
  end

endmodule

@@ design/cramer_3x3_solver_top.sv @@
// 3x3 linear system solver by cramer's rule, signed fixed point
// depends on cr3_pkg, cr3_det, cr3_div
//
// Accepts one system per clock while the pipeline is not held and returns one
// solution per request. Each system passes through the four determinant
// pipelines (2x2 minor products, minors, split cofactor products, cofactor
// terms, sum) and then the three divider pipelines (sign and magnitude, range
// check, 32 quotient bits one per stage, saturation). The whole pipeline
// advances together and holds while a result waits at the output, so in_ready
// follows out_ready whenever out_valid is high. A zero determinant gives
// singular = 1 and -1.0 in all three outputs; quotients out of range saturate.
module cramer_3x3_solver_top import cr3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] a00,
  input  logic signed [DATA_W-1:0] a01,
  input  logic signed [DATA_W-1:0] a02,
  input  logic signed [DATA_W-1:0] a10,
  input  logic signed [DATA_W-1:0] a11,
  input  logic signed [DATA_W-1:0] a12,
  input  logic signed [DATA_W-1:0] a20,
  input  logic signed [DATA_W-1:0] a21,
  input  logic signed [DATA_W-1:0] a22,
  input  logic signed [DATA_W-1:0] rhs0,
  input  logic signed [DATA_W-1:0] rhs1,
  input  logic signed [DATA_W-1:0] rhs2,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] sol0,
  output logic signed [DATA_W-1:0] sol1,
  output logic signed [DATA_W-1:0] sol2,
  output logic                     singular
);

  localparam int LAT = DET_LAT + DIV_LAT;

  logic                     en;
  logic [LAT-1:0]           vld;
  logic signed [DATA_W-1:0] mat  [4][9];
  logic signed [DW-1:0]     dets [4];
  logic [DATA_W-1:0]        sols [3];
  logic                     sing [3];

  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // main matrix, then column k replaced by the right-hand vector
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mat[k] = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
    end
    for (int k = 0; k < 3; k++) begin
      mat[k+1][k]   = rhs0;
      mat[k+1][3+k] = rhs1;
      mat[k+1][6+k] = rhs2;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_det
    cr3_det u_det (
      .clk (clk),
      .en  (en),
      .m   (mat[k]),
      .det (dets[k])
    );
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    cr3_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk      (clk),
      .en       (en),
      .num      (dets[k+1]),
      .den      (dets[0]),
      .sol      (sols[k]),
      .singular (sing[k])
    );
  end

  assign sol0     = $signed(sols[0]);
  assign sol1     = $signed(sols[1]);
  assign sol2     = $signed(sols[2]);
  assign singular = sing[0] & sing[1] & sing[2];

endmodule

@@ design/cr3_checker.sv @@
// port-level checks for the cramer solver top, attached by bind
// depends on cr3_pkg and cramer_3x3_solver_top
module cr3_checker import cr3_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] sol0,
  input logic [DATA_W-1:0] sol1,
  input logic [DATA_W-1:0] sol2,
  input logic              singular
);

  localparam logic [DATA_W-1:0] NEG_ONE = ~((DATA_W'(1) << FRAC_BITS) - DATA_W'(1));

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("pipeline advance does not follow output side");

  a_sing: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> sol0 == NEG_ONE && sol1 == NEG_ONE && sol2 == NEG_ONE)
    else $error("singular result without -1.0 outputs");

endmodule

bind cramer_3x3_solver_top cr3_checker #(.FRAC_BITS(FRAC_BITS)) u_cr3_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sol0      (sol0),
  .sol1      (sol1),
  .sol2      (sol2),
  .singular  (singular)
);
